[sv/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared widths, codes and types for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // result tdata: front, rear, occupancy, padded to whole bytes
  localparam int RES_W      = 2 * WORD_W + OCC_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OCC_W-1:0]    occ_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_QUERY      = 3'd4;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_UNDER = 2'd1;
  localparam status_t STATUS_OVER  = 2'd2;

endpackage

[sv/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Deque of signed 32-bit words in a ring buffer RAM, one result per command.
// Push and query commands: result in the cycle after the transfer, one per
// cycle while results are taken. A pop that leaves the queue non-empty reads
// the new end word from the RAM port in ST_READ, holding s_tready low, and
// its result follows. Front and rear words are kept in the result registers;
// the RAM read port is only needed when a pop exposes a new end.
// Reset: head and count cleared (queue empty), no result pending; RAM
// contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [deq_pkg::WORD_W-1:0]      s_tdata,   // [31:0] push_value
  input  logic [deq_pkg::CMD_W-1:0]       s_tuser,   // [2:0] cmd
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [deq_pkg::OUT_DATA_W-1:0]  m_tdata,   // [31:0] front_value,
                                                     // [63:32] rear_value,
                                                     // [68:64] occupancy, pad
  output logic [deq_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                  state, state_next;
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  logic                  pend_front, pend_front_next;
  deq_pkg::word_t        front, front_next;
  deq_pkg::word_t        rear, rear_next;
  deq_pkg::status_t      status, status_next;
  logic                  m_tvalid_next;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  deq_pkg::word_t        ram_rdata;

  logic                  accept;
  logic                  go_read;
  deq_pkg::cmd_t         cmd;
  deq_pkg::word_t        word;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] i);
    logic [SW-1:0] r;
    r = (i >= DEPTH_S) ? i - DEPTH_S : i;
    return r[AW-1:0];
  endfunction

  assign cmd      = s_tuser;
  assign word     = s_tdata;
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    pend_front_next = pend_front;
    front_next      = front;
    rear_next       = rear;
    status_next     = status;
    m_tvalid_next   = m_tvalid && !m_tready;
    ram_we          = 1'b0;
    ram_waddr       = head;
    ram_re          = 1'b0;
    ram_raddr       = head;
    go_read         = 1'b0;

    if (state == ST_READ) begin
      // new end word arrives from the RAM
      if (pend_front) begin
        front_next = ram_rdata;
      end else begin
        rear_next = ram_rdata;
      end
      m_tvalid_next = 1'b1;
      state_next    = ST_IDLE;
    end else if (accept) begin
      m_tvalid_next = 1'b1;
      status_next   = deq_pkg::STATUS_OK;
      unique case (cmd) inside
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
          if (count == DEPTH_C) begin
            status_next = deq_pkg::STATUS_OVER;
          end else begin
            ram_we     = 1'b1;
            count_next = count + CW'(1);
            if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
              head_next  = (head == '0) ? LAST_IX : head - AW'(1);
              ram_waddr  = head_next;
              front_next = word;
              if (count == '0) begin
                rear_next = word;
              end
            end else begin
              ram_waddr = wrap(SW'(head) + SW'(count));
              rear_next = word;
              if (count == '0) begin
                front_next = word;
              end
            end
          end
        end
        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
          if (count == '0) begin
            status_next = deq_pkg::STATUS_UNDER;
          end else begin
            count_next      = count - CW'(1);
            pend_front_next = (cmd == deq_pkg::CMD_POP_FRONT);
            if (cmd == deq_pkg::CMD_POP_FRONT) begin
              head_next = wrap(SW'(head) + SW'(1));
              ram_raddr = head_next;
            end else begin
              ram_raddr = wrap(SW'(head) + SW'(count) - SW'(2));
            end
            if (count == CW'(1)) begin
              front_next = '0;
              rear_next  = '0;
            end else begin
              ram_re        = 1'b1;
              go_read       = 1'b1;
              m_tvalid_next = 1'b0;
              state_next    = ST_READ;
            end
          end
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      front    <= '0;
      rear     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      front    <= front_next;
      rear     <= rear_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_front <= pend_front_next;
    status     <= status_next;
  end

  deq_ram #(
    .WIDTH (deq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tdata = {{(deq_pkg::OUT_DATA_W - deq_pkg::RES_W){1'b0}},
                    deq_pkg::occ_t'(count), rear, front};
  assign m_tuser = status;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("element count above depth");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (!s_tready && !m_tvalid))
    else $error("transfer or result during RAM read");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && go_read) |=> (state == ST_READ) ##1 m_tvalid)
    else $error("pop result not delivered after RAM read");

  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == deq_pkg::STATUS_UNDER)
      |-> (count == '0 && front == '0 && rear == '0))
    else $error("underflow result with non-empty queue");

endmodule
